[rtl/tspf_pkg.sv]
// Shared constants and types for the transport stream PID filter.
package tspf_pkg;
	localparam int ENTRIES = 8;
	localparam int PACKET_BYTES = 188;
	localparam int IDX_W = 3;
	localparam int POS_W = 8;
	localparam logic [7:0] SYNC_VALUE = 8'h47;
	localparam logic [7:0] ERR_BIT = 8'h80;
	localparam logic [4:0] PID_HI_MASK = 5'h1f;

	localparam logic [2:0] OP_BYTE = 3'd0;
	localparam logic [2:0] OP_TICK = 3'd1;
	localparam logic [2:0] OP_OVF = 3'd2;
	localparam logic [2:0] OP_LOAD = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] stream_byte;
		logic [2:0] entry_index;
		logic [12:0] entry_pid;
		logic [31:0] entry_start;
		logic [31:0] entry_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [7:0] route_mask;
		logic packet_end;
		logic run_last;
		logic [63:0] packet_count;
		logic [63:0] error_count;
		logic [31:0] overflow_count;
		logic entry_done;
		logic all_done;
	} out_item_t;

	// command broadcast into the cell row
	typedef struct packed {
		logic route;
		logic tick;
		logic ovf;
		logic load;
		logic [12:0] pid;
		logic err;
		logic [31:0] second;
		logic [31:0] ld_start;
		logic [31:0] ld_end;
	} cell_cmd_t;

	// state passed from cell to cell
	typedef struct packed {
		logic [63:0] pk;
		logic [63:0] er;
		logic [31:0] ov;
		logic done;
	} cell_rd_t;
endpackage

[rtl/tspf_if.sv]
// Valid/ready channel interfaces for input items, result items and config.
interface tspf_in_if;
	import tspf_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tspf_out_if;
	import tspf_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tspf_cfg_if;
	logic valid;
	logic ready;
	logic [3:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/tspf_cell.sv]
// One PID table entry with its counters; reports chain to the neighbor.
module tspf_cell (
	input logic clk,
	input logic arst_n,
	input tspf_pkg::cell_cmd_t cmd,
	input logic live,
	input logic sel,
	input logic shift,
	input tspf_pkg::cell_rd_t chain_in,
	output tspf_pkg::cell_rd_t chain_out,
	output logic hit,
	output logic done
);
	import tspf_pkg::*;
	logic [12:0] pid_q;
	logic [31:0] start_q, end_q;
	logic done_q;
	logic [63:0] pk_q, er_q;
	logic [31:0] ov_q;
	cell_rd_t hold_q;

	assign hit = live && !done_q && pid_q == cmd.pid && !(cmd.second < start_q);
	assign done = done_q;
	assign chain_out = hold_q;

	always_ff @(posedge clk) begin
		if (cmd.load && sel) begin
			pid_q <= cmd.pid;
			start_q <= cmd.ld_start;
			end_q <= cmd.ld_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			pk_q <= '0;
			er_q <= '0;
			ov_q <= '0;
			hold_q <= '0;
		end else begin
			// shift toward the end of the row on request, else capture this cell's counters
			if (shift) hold_q <= chain_in;
			else hold_q <= '{pk: pk_q, er: er_q, ov: ov_q, done: done_q};
			if (cmd.load && sel) begin
				done_q <= 1'b0;
				pk_q <= '0;
				er_q <= '0;
				ov_q <= '0;
			end else if (cmd.route && hit) begin
				pk_q <= pk_q + 64'd1;
				if (cmd.err) er_q <= er_q + 64'd1;
			end else if (cmd.tick && live && !done_q && cmd.second > end_q) begin
				done_q <= 1'b1;
			end else if (cmd.ovf && live && !done_q && ov_q != '1) begin
				ov_q <= ov_q + 32'd1;
			end
		end
	end
endmodule

[rtl/ts_pid_filter_router.sv]
// Top level: framing, control sequencer and the row of table cells.
// One transaction at a time: input is taken only when idle with no result held.
// Stream byte: a routed byte's result is registered on accept; a routed header third byte gives
// three results, one per cycle the sink takes. Tick/overflow: status passes ST_STAT, then ST_OUT.
// Read: the report shifts down the row in ST_READ (entry ENTRIES-1 soonest), then goes out via ST_OUT.
// Reset clears counters, done flags and framing; table contents stay undefined.
module ts_pid_filter_router (
	input logic clk,
	input logic arst_n,
	tspf_in_if.sink in_ch,
	tspf_out_if.source out_ch,
	tspf_cfg_if.sink cfg
);
	import tspf_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR = 3'd1;
	localparam logic [2:0] ST_STAT = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;
	localparam int CNT_W = $clog2(ENTRIES + 2);

	logic [2:0] state_q;
	logic [3:0] active_q;
	logic [31:0] second_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0] hdr0_q;
	logic [ENTRIES-1:0] mask_q;
	logic [1:0] hcnt_q;
	logic [7:0] b2_q;
	logic pend_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [IDX_W-1:0] ridx_q;
	logic ovalid_q;
	out_item_t obuf_q;

	cell_cmd_t cmd;
	cell_rd_t chain [ENTRIES+1];
	logic [ENTRIES-1:0] live, hit, done_v, sel;
	logic shift;
	logic acc, all_done;
	logic [POS_W:0] n_live;

	function automatic out_item_t mk_item(logic [1:0] k, logic [7:0] b, logic [7:0] m,
			logic pe, logic rl);
		out_item_t r;
		r = '0;
		r.kind = k;
		r.out_byte = b;
		r.route_mask = m;
		r.packet_end = pe;
		r.run_last = rl;
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) active_q <= '0;
		else if (cfg.valid) active_q <= cfg.data;
	end
	assign n_live = (active_q > 4'(ENTRIES)) ? (POS_W+1)'(ENTRIES) : (POS_W+1)'(active_q);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			live[i] = (POS_W+1)'(i) < n_live;
			sel[i] = in_ch.data.entry_index == IDX_W'(i);
		end
	end
	assign all_done = &(done_v | ~live);

	assign in_ch.ready = state_q == ST_IDLE && !ovalid_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign shift = state_q == ST_READ;

	always_comb begin
		cmd = '0;
		cmd.second = second_q;
		cmd.ld_start = in_ch.data.entry_start;
		cmd.ld_end = in_ch.data.entry_end;
		cmd.pid = in_ch.data.entry_pid;
		cmd.err = hdr0_q[7];
		if (acc) begin
			unique case (in_ch.data.op)
				OP_BYTE: begin
					cmd.route = pos_q == POS_W'(2);
					cmd.pid = {hdr0_q[4:0] & PID_HI_MASK, in_ch.data.stream_byte};
				end
				OP_OVF: cmd.ovf = 1'b1;
				OP_LOAD: cmd.load = 1'b1;
				default: ;
			endcase
		end
		if (state_q == ST_STAT && obuf_q.kind == KIND_STATUS && obuf_q.route_mask[0])
			cmd.tick = 1'b1;
	end

	assign chain[0] = '0;
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		tspf_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .live(live[g]), .sel(sel[g]),
			.shift(shift), .chain_in(chain[g]), .chain_out(chain[g+1]),
			.hit(hit[g]), .done(done_v[g])
		);
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = obuf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			second_q <= '0;
			pos_q <= '0;
			hdr0_q <= '0;
			mask_q <= '0;
			hcnt_q <= '0;
			b2_q <= '0;
			pend_q <= 1'b0;
			rcnt_q <= '0;
			ridx_q <= '0;
			ovalid_q <= 1'b0;
			obuf_q <= '0;
		end else begin
			// header results stay valid back to back until the last one goes
			if (out_ch.ready && ovalid_q && state_q != ST_HDR) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (acc) begin
					unique case (in_ch.data.op)
						OP_BYTE: begin
							if (pos_q == '0) begin
								if (in_ch.data.stream_byte == SYNC_VALUE) pos_q <= POS_W'(1);
							end else if (pos_q == POS_W'(1)) begin
								hdr0_q <= in_ch.data.stream_byte;
								pos_q <= POS_W'(2);
							end else begin
								pos_q <= (pos_q == POS_W'(PACKET_BYTES-1)) ? '0 : pos_q + 1'b1;
								if (pos_q == POS_W'(2)) begin
									mask_q <= hit;
									b2_q <= in_ch.data.stream_byte;
									pend_q <= PACKET_BYTES <= 3;
									if (hit != '0) begin
										obuf_q <= mk_item(KIND_BYTE, SYNC_VALUE, 8'(hit),
											1'b0, 1'b0);
										ovalid_q <= 1'b1;
										hcnt_q <= 2'd1;
										state_q <= ST_HDR;
									end
								end else if (mask_q != '0) begin
									obuf_q <= mk_item(KIND_BYTE, in_ch.data.stream_byte,
										8'(mask_q), pos_q == POS_W'(PACKET_BYTES-1), 1'b1);
									ovalid_q <= 1'b1;
								end
							end
						end
						OP_TICK: begin
							if (second_q != '1) second_q <= second_q + 32'd1;
							// route_mask bit 0 marks a tick for the next cycle
							obuf_q <= mk_item(KIND_STATUS, 8'd0, 8'd1, 1'b0, 1'b0);
							state_q <= ST_STAT;
						end
						OP_OVF: begin
							obuf_q <= mk_item(KIND_STATUS, 8'd0, 8'd0, 1'b0, 1'b0);
							state_q <= ST_STAT;
						end
						OP_READ: begin
							ridx_q <= in_ch.data.entry_index;
							rcnt_q <= '0;
							obuf_q <= mk_item(KIND_REPORT, 8'd0, 8'd0, 1'b0, 1'b0);
							state_q <= ST_READ;
						end
						default: ;
					endcase
				end
				ST_HDR: if (out_ch.ready) begin
					hcnt_q <= hcnt_q + 2'd1;
					if (hcnt_q == 2'd1) obuf_q.out_byte <= hdr0_q;
					else begin
						obuf_q.out_byte <= b2_q;
						obuf_q.packet_end <= pend_q;
						obuf_q.run_last <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_STAT: begin
					obuf_q.route_mask <= '0;
					state_q <= ST_OUT;
				end
				ST_READ: begin
					// entry i reaches the row end once rcnt_q equals ENTRIES-1-i
					rcnt_q <= rcnt_q + 1'b1;
					if (rcnt_q == CNT_W'(ENTRIES - 1) - CNT_W'(ridx_q)) begin
						obuf_q.packet_count <= chain[ENTRIES].pk;
						obuf_q.error_count <= chain[ENTRIES].er;
						obuf_q.overflow_count <= chain[ENTRIES].ov;
						obuf_q.entry_done <= chain[ENTRIES].done;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					obuf_q.run_last <= 1'b1;
					obuf_q.all_done <= all_done;
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/tspf_checker.sv]
// Port-level checks for the PID filter router, bound to the top level.
module tspf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input tspf_pkg::out_item_t out_data
);
	import tspf_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind != 2'd3) else $error("bad kind");
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_BYTE |-> out_data.route_mask != '0)
		else $error("unrouted byte");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_BYTE |-> out_data.run_last)
		else $error("status not last");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid) else $error("input taken with result held");
endmodule

bind ts_pid_filter_router tspf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
